// File: design/radial_vignette_flash_tint_unit_defines.svh
// assertion macros for the radial vignette flash tint unit
`ifndef RADIAL_VIGNETTE_FLASH_TINT_UNIT_DEFINES_SVH
`define RADIAL_VIGNETTE_FLASH_TINT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RVFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RVFT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RVFT_ASSERT(lbl, prop, msg)
`define RVFT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: design/rvft_pkg.sv
package rvft_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int FIELD_W    = 12;
  localparam int INV_W      = 16;
  localparam int PIX_W      = 32;
  localparam int PROD_W     = COORD_BITS + INV_W;
  localparam int MAG_W      = (PROD_W > 31) ? 31 : PROD_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int ROOT_W     = (SUM_W + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int EDGE_W     = FRAC_BITS + 1;
  localparam int MIX_W      = 9;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] INNER_RADIUS_RST = 16'd19661;
  localparam logic [15:0] RAMP_GAIN_RST    = 16'd1280;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLASH_MIX     = 3'd0,
    CFG_TINT_STRENGTH = 3'd1,
    CFG_INV_WIDTH     = 3'd2,
    CFG_INV_HEIGHT    = 3'd3,
    CFG_INNER_RADIUS  = 3'd4,
    CFG_RAMP_GAIN     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [MIX_W-1:0] flash_mix;
    logic [MIX_W-1:0] tint_strength;
    logic [15:0]      inv_width;
    logic [15:0]      inv_height;
    logic [15:0]      inner_radius;
    logic [15:0]      ramp_gain;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] rad;
    logic [PIX_W-1:0] pix;
  } sum_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [PIX_W-1:0]  pix;
  } root_t;

  typedef struct packed {
    logic [ROOT_W-1:0] distance;
    logic [PIX_W-1:0]  pix;
  } dist_t;

endpackage

// File: design/rvft_front.sv
module rvft_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rvft_pkg::FIELD_W-1:0] pixel_x_i,
  input  logic [rvft_pkg::FIELD_W-1:0] pixel_y_i,
  input  logic [rvft_pkg::PIX_W-1:0] pixel_in_i,
  input  rvft_pkg::cfg_t             cfg_i,
  output logic                       valid_o,
  output rvft_pkg::sum_t             data_o
);

  localparam int PW = rvft_pkg::PROD_W;
  localparam int MW = rvft_pkg::MAG_W;
  localparam int SW = rvft_pkg::SQ_W;
  localparam int UW = rvft_pkg::SUM_W;
  localparam int CB = rvft_pkg::COORD_BITS;
  localparam logic [PW-1:0] HALF    = PW'(64'd1 << (rvft_pkg::FRAC_BITS - 1));
  localparam logic [PW-1:0] MAG_LIM = PW'((64'd1 << MW) - 64'd1);

  function automatic logic [7:0] flash_ch(input logic [7:0] c, input logic [8:0] m);
    logic [16:0] prod;
    logic [8:0]  sum;
    prod = 17'(8'hFF - c) * 17'(m);
    sum  = 9'(c) + prod[16:8];
    return (sum > 9'd255) ? 8'hFF : sum[7:0];
  endfunction

  function automatic logic [MW-1:0] offset_mag(input logic [PW-1:0] p);
    logic [PW-1:0] m;
    m = (p >= HALF) ? (p - HALF) : (HALF - p);
    return (m > MAG_LIM) ? MAG_LIM[MW-1:0] : m[MW-1:0];
  endfunction

  logic [15:0]    x_ext, y_ext;
  logic [8:0]     mix;
  logic [rvft_pkg::PIX_W-1:0] a_pix_d, a_pix_q, b_pix_q, c_pix_q, d_pix_q;
  logic [PW-1:0]  a_px_d, a_py_d, a_px_q, a_py_q;
  logic [MW-1:0]  b_dx_q, b_dy_q;
  logic [SW-1:0]  c_sx_q, c_sy_q;
  logic [UW-1:0]  d_sum_q;
  logic           va_q, vb_q, vc_q, vd_q;

  always_comb begin
    x_ext = 16'(pixel_x_i);
    y_ext = 16'(pixel_y_i);
    mix   = (cfg_i.flash_mix > 9'd256) ? 9'd256 : cfg_i.flash_mix;
    if (cfg_i.flash_mix != '0) begin
      a_pix_d = {8'h00, flash_ch(pixel_in_i[23:16], mix), flash_ch(pixel_in_i[15:8], mix),
                 flash_ch(pixel_in_i[7:0], mix)};
    end else begin
      a_pix_d = pixel_in_i;
    end
    a_px_d = PW'(x_ext[CB-1:0]) * PW'(cfg_i.inv_width);
    a_py_d = PW'(y_ext[CB-1:0]) * PW'(cfg_i.inv_height);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_pix_q <= a_pix_d;
      a_px_q  <= a_px_d;
      a_py_q  <= a_py_d;
      b_pix_q <= a_pix_q;
      b_dx_q  <= offset_mag(a_px_q);
      b_dy_q  <= offset_mag(a_py_q);
      c_pix_q <= b_pix_q;
      c_sx_q  <= SW'(b_dx_q) * SW'(b_dx_q);
      c_sy_q  <= SW'(b_dy_q) * SW'(b_dy_q);
      d_pix_q <= c_pix_q;
      d_sum_q <= UW'(c_sx_q) + UW'(c_sy_q);
    end
  end

  assign valid_o  = vd_q;
  assign data_o.rad = d_sum_q;
  assign data_o.pix = d_pix_q;

endmodule

// File: design/rvft_sqrt_stage.sv
module rvft_sqrt_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rvft_pkg::root_t data_i,
  output logic            valid_o,
  output rvft_pkg::root_t data_o
);

  localparam int RW = rvft_pkg::RAD_W;
  localparam int EW = rvft_pkg::REM_W;
  localparam int QW = rvft_pkg::ROOT_W;

  logic [EW-1:0]   trial_rem, trial;
  logic            ge;
  rvft_pkg::root_t data_d, data_q;
  logic            valid_q;

  always_comb begin
    trial_rem   = {data_i.rem[EW-3:0], data_i.rad[RW-1:RW-2]};
    trial       = {data_i.root, 2'b01};
    ge          = trial_rem >= trial;
    data_d.rad  = {data_i.rad[RW-3:0], 2'b00};
    data_d.rem  = ge ? (trial_rem - trial) : trial_rem;
    data_d.root = {data_i.root[QW-2:0], ge};
    data_d.pix  = data_i.pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/rvft_back.sv
module rvft_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  rvft_pkg::dist_t            data_i,
  input  rvft_pkg::cfg_t             cfg_i,
  output logic                       valid_o,
  output logic [rvft_pkg::PIX_W-1:0] pixel_o
);

  localparam int QW = rvft_pkg::ROOT_W;
  localparam int GW = QW + 16;
  localparam int HW = QW + 8;
  localparam int EW = rvft_pkg::EDGE_W;
  localparam int FW = EW + 9;
  localparam logic [HW-1:0] ONE = HW'(64'd1 << rvft_pkg::FRAC_BITS);

  function automatic logic [7:0] raise_ch(input logic [7:0] c, input logic [8:0] f);
    logic [16:0] prod;
    logic [8:0]  sum;
    prod = 17'(8'hFF - c) * 17'(f);
    sum  = 9'(c) + prod[16:8];
    return (sum > 9'd255) ? 8'hFF : sum[7:0];
  endfunction

  function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [8:0] f);
    logic [16:0] prod;
    prod = 17'(c) * 17'(9'd256 - f);
    return prod[15:8];
  endfunction

  logic [rvft_pkg::PIX_W-1:0] e_pix_q, f_pix_q, g_pix_q, h_pix_q;
  logic [QW-1:0] inner_ext, e_diff_q;
  logic [GW-1:0] f_prod;
  logic [EW-1:0] f_edge_q;
  logic [FW-1:0] g_prod;
  logic [8:0]    g_mix_q;
  logic          g_on_q;
  logic          ve_q, vf_q, vg_q, vh_q;

  always_comb begin
    inner_ext = QW'(cfg_i.inner_radius);
    f_prod    = GW'(e_diff_q) * GW'(cfg_i.ramp_gain);
    g_prod    = FW'(f_edge_q) * FW'(cfg_i.tint_strength);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
    end else if (en_i) begin
      ve_q <= valid_i;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_pix_q  <= data_i.pix;
      e_diff_q <= (data_i.distance > inner_ext) ? (data_i.distance - inner_ext) : '0;
      f_pix_q  <= e_pix_q;
      f_edge_q <= (f_prod[GW-1:8] > ONE) ? ONE[EW-1:0] : f_prod[EW+7:8];
      g_pix_q  <= f_pix_q;
      g_mix_q  <= (g_prod[FW-1:rvft_pkg::FRAC_BITS] > 10'd256) ? 9'd256
                : g_prod[rvft_pkg::FRAC_BITS+8:rvft_pkg::FRAC_BITS];
      g_on_q   <= (f_edge_q != '0) && (cfg_i.tint_strength != '0);
      if (g_on_q) begin
        h_pix_q <= {8'h00, raise_ch(g_pix_q[23:16], g_mix_q), scale_ch(g_pix_q[15:8], g_mix_q),
                    scale_ch(g_pix_q[7:0], g_mix_q)};
      end else begin
        h_pix_q <= g_pix_q;
      end
    end
  end

  assign valid_o = vh_q;
  assign pixel_o = h_pix_q;

endmodule

// File: design/rvft_out_buf.sv
`include "radial_vignette_flash_tint_unit_defines.svh"

module rvft_out_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [rvft_pkg::PIX_W-1:0] data_i,
  output logic                       en_o,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [rvft_pkg::PIX_W-1:0] m_tdata_o
);

  logic                       out_v_q, skid_v_q;
  logic [rvft_pkg::PIX_W-1:0] out_q, skid_q;
  logic                       take;

  assign en_o = !skid_v_q;
  assign take = !out_v_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_tready_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (take) begin
      out_v_q <= valid_i;
    end else if (valid_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_tready_i) begin
        out_q <= skid_q;
      end
    end else if (take) begin
      out_q <= data_i;
    end else begin
      skid_q <= data_i;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_q;

  // held result stays, spare result waits behind it
  `RVFT_ASSERT(skid_needs_out_a, skid_v_q |-> out_v_q, "skid full without output")
  `RVFT_ASSERT(skid_drain_a, (skid_v_q && m_tready_i) |=> (!skid_v_q && out_v_q), "skid not moved")
  `RVFT_ASSERT(skid_hold_a, (skid_v_q && !m_tready_i) |=> skid_v_q, "skid lost while stalled")
  `RVFT_ASSERT_RST(reset_idle_a, !rst_ni |-> (!out_v_q && !skid_v_q), "valid during reset")

endmodule

// File: design/radial_vignette_flash_tint_unit.sv
// radial vignette and flash tint on an ARGB8888 pixel stream
// s_* channel: one pixel per transfer with its column and row; m_* channel: one processed
// pixel per transfer, in input order. cfg_* channel writes one register per transfer
// (0 flash_mix, 1 tint_strength, 2 inv_width, 3 inv_height, 4 inner_radius, 5 ramp_gain);
// it is always ready and is meant to be used while no pixel is in flight.
// throughput: one pixel per clock while the output is not stalled.
// pipeline: the square root resolves one root bit per pipeline stage; before it lie four stages
// of flash, offset and squaring, after it four of edge ramp and tint, then the output register.
// all stages move together on one enable; when m_tready_i is low the pipeline keeps
// advancing until a result needs the spare output slot, then s_tready_o drops and comes
// back as soon as the spare slot drains. nothing is lost or repeated across a stall.
// reset: the pipeline empties, registers return to flash and tint off, inner radius 0.3,
// ramp gain 5.0, reciprocals zero.
module radial_vignette_flash_tint_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [55:0]                     s_tdata_i,  // pixel_x, pixel_y, pixel_in
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [31:0]                     m_tdata_o,  // pixel_out
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rvft_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rvft_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int QW = rvft_pkg::ROOT_W;

  rvft_pkg::cfg_t  cfg_d, cfg_q;
  logic            en;
  logic            front_v;
  rvft_pkg::sum_t  front_data;
  logic            sq_v [QW+1];
  rvft_pkg::root_t sq_data [QW+1];
  rvft_pkg::dist_t back_in;
  logic            back_v;
  logic [31:0]     back_pix;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (rvft_pkg::cfg_idx_e'(cfg_index_i))
        rvft_pkg::CFG_FLASH_MIX:     cfg_d.flash_mix     = cfg_data_i[8:0];
        rvft_pkg::CFG_TINT_STRENGTH: cfg_d.tint_strength = cfg_data_i[8:0];
        rvft_pkg::CFG_INV_WIDTH:     cfg_d.inv_width     = cfg_data_i;
        rvft_pkg::CFG_INV_HEIGHT:    cfg_d.inv_height    = cfg_data_i;
        rvft_pkg::CFG_INNER_RADIUS:  cfg_d.inner_radius  = cfg_data_i;
        rvft_pkg::CFG_RAMP_GAIN:     cfg_d.ramp_gain     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flash_mix     <= '0;
      cfg_q.tint_strength <= '0;
      cfg_q.inv_width     <= '0;
      cfg_q.inv_height    <= '0;
      cfg_q.inner_radius  <= rvft_pkg::INNER_RADIUS_RST;
      cfg_q.ramp_gain     <= rvft_pkg::RAMP_GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign s_tready_o = en;

  rvft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_tvalid_i),
    .pixel_x_i  (s_tdata_i[11:0]),
    .pixel_y_i  (s_tdata_i[23:12]),
    .pixel_in_i (s_tdata_i[55:24]),
    .cfg_i      (cfg_q),
    .valid_o    (front_v),
    .data_o     (front_data)
  );

  assign sq_v[0]         = front_v;
  assign sq_data[0].rad  = rvft_pkg::RAD_W'(front_data.rad);
  assign sq_data[0].rem  = '0;
  assign sq_data[0].root = '0;
  assign sq_data[0].pix  = front_data.pix;

  for (genvar i = 0; i < QW; i++) begin : g_sqrt
    rvft_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .data_i  (sq_data[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq_data[i+1])
    );
  end

  assign back_in.distance = sq_data[QW].root;
  assign back_in.pix      = sq_data[QW].pix;

  rvft_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v[QW]),
    .data_i  (back_in),
    .cfg_i   (cfg_q),
    .valid_o (back_v),
    .pixel_o (back_pix)
  );

  rvft_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (back_v),
    .data_i     (back_pix),
    .en_o       (en),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule
